// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion lbl failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))

`endif

// File: rtl/lcw_pkg.sv
// Shared constants and types of the line clipping window unit.
`default_nettype none
package lcw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_BITS   = 4;

  localparam int WIN_LEFT_RST   = 150;
  localparam int WIN_RIGHT_RST  = 450;
  localparam int WIN_TOP_RST    = 100;
  localparam int WIN_BOTTOM_RST = 350;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 4'd3;

  // Outcode bit positions.
  localparam int OC_ABOVE = 0;
  localparam int OC_BELOW = 1;
  localparam int OC_RIGHT = 2;
  localparam int OC_LEFT  = 3;

  typedef enum logic [1:0] {
    OUT_INSIDE = 2'd0,
    OUT_REJECT = 2'd1,
    OUT_CLIP   = 2'd2
  } outcome_e;

endpackage
`default_nettype wire

// File: rtl/lcw_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module lcw_div_pipe #(
  parameter int CoordBits = 12
) (
  input  logic                     clk_i,
  input  logic [2*CoordBits-1:0]   dividend_i,
  input  logic [CoordBits-1:0]     divisor_i,
  output logic [CoordBits-1:0]     quotient_o
);
  localparam int N = CoordBits;

  logic [N-1:0] rem_q [N];
  logic [N-1:0] low_q [N];
  logic [N-1:0] quo_q [N];
  logic [N-1:0] div_q [N];

  // The quotient is known to fit N bits, so the upper half starts below the divisor.
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N-1:0] rem_in, low_in, quo_in, div_in;
    logic [N:0]   trial;
    logic [N+1:0] diff;
    if (k == 0) begin : g_first
      assign rem_in = dividend_i[2*N-1:N];
      assign low_in = dividend_i[N-1:0];
      assign quo_in = '0;
      assign div_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign div_in = div_q[k-1];
    end
    assign trial = {rem_in, low_in[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_in};
    always_ff @(posedge clk_i) begin
      if (!diff[N+1]) begin
        rem_q[k] <= diff[N-1:0];
        quo_q[k] <= {quo_in[N-2:0], 1'b1};
      end else begin
        rem_q[k] <= trial[N-1:0];
        quo_q[k] <= {quo_in[N-2:0], 1'b0};
      end
      low_q[k] <= {low_in[N-2:0], 1'b0};
      div_q[k] <= div_in;
    end
  end

  assign quotient_o = quo_q[N-1];

endmodule
`default_nettype wire

// File: rtl/line_clip_window_unit.sv
// Top level of the pipelined line clipping window unit.
//
//   channel   direction  handshake                     payload
//   request   in         start high, busy low          first_x/y, second_x/y
//   result    out        result_valid_o for one cycle  outcome, clip endpoints
//   config    in         cfg_valid_i and cfg_ready_o   cfg_index_i, cfg_data_i
//
// One segment is taken every cycle; busy is always low and cfg_ready_o always high.
// A result passes through an outcode and difference stage, a multiply stage,
// CoordBits divider stages and a final select stage.
// The divider's quotient bit per stage sets the depth.
// Reset clears the valid bits and sets the window to its default.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module line_clip_window_unit #(
  parameter int CoordBits = lcw_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [CoordBits-1:0]      first_x_i,
  input  logic signed [CoordBits-1:0]      first_y_i,
  input  logic signed [CoordBits-1:0]      second_x_i,
  input  logic signed [CoordBits-1:0]      second_y_i,
  output logic                             result_valid_o,
  output logic [1:0]                       outcome_o,
  output logic signed [CoordBits-1:0]      clip_first_x_o,
  output logic signed [CoordBits-1:0]      clip_first_y_o,
  output logic signed [CoordBits-1:0]      clip_second_x_o,
  output logic signed [CoordBits-1:0]      clip_second_y_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lcw_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CoordBits-1:0]             cfg_data_i
);
  import lcw_pkg::*;
  `include "assert_macros.svh"

  localparam int N   = CoordBits;
  localparam int LAT = N + 3;

  typedef struct packed {
    outcome_e     outcome;
    logic [N-1:0] x1, y1, x2, y2;
    logic [3:0]   c1, c2;
    logic [N-1:0] ex1, ey1, ex2, ey2;
    logic [3:0]   neg;
  } sb_t;

  logic [N-1:0] left_q, right_q, top_q, bottom_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= N'(WIN_LEFT_RST);
      right_q  <= N'(WIN_RIGHT_RST);
      top_q    <= N'(WIN_TOP_RST);
      bottom_q <= N'(WIN_BOTTOM_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] outcode(input logic [N-1:0] x, input logic [N-1:0] y);
    logic [3:0] c;
    c = '0;
    c[OC_ABOVE] = $signed(y) < $signed(top_q);
    c[OC_BELOW] = $signed(y) > $signed(bottom_q);
    c[OC_RIGHT] = $signed(x) > $signed(right_q);
    c[OC_LEFT]  = $signed(x) < $signed(left_q);
    return c;
  endfunction

  function automatic logic [N:0] sub(input logic [N-1:0] p, input logic [N-1:0] q);
    return {p[N-1], p} - {q[N-1], q};
  endfunction

  function automatic logic [N-1:0] mag(input logic [N:0] v);
    logic [N:0] m;
    m = v[N] ? (~v + 1'b1) : v;
    return m[N-1:0];
  endfunction

  // Stage A: outcodes, chosen edges, differences and their magnitudes.
  logic       take;
  logic [3:0] c1, c2;
  logic [N-1:0] ex1, ey1, ex2, ey2;
  logic [N:0] da [4];
  logic [N:0] db [4];
  logic [N:0] dd [4];
  outcome_e   outc;

  assign take = start && !busy;

  // The outcodes also depend on the window registers, so they are evaluated in a process.
  always_comb begin
    c1 = outcode(first_x_i, first_y_i);
    c2 = outcode(second_x_i, second_y_i);
  end

  assign ex1  = c1[OC_RIGHT] ? right_q : left_q;
  assign ey1  = c1[OC_BELOW] ? bottom_q : top_q;
  assign ex2  = c2[OC_RIGHT] ? right_q : left_q;
  assign ey2  = c2[OC_BELOW] ? bottom_q : top_q;

  always_comb begin
    if (c1 == 4'd0 && c2 == 4'd0) outc = OUT_INSIDE;
    else if ((c1 & c2) != 4'd0)   outc = OUT_REJECT;
    else                          outc = OUT_CLIP;
    // Paths: side move of the first end, top/bottom move of the first end, then the second.
    da[0] = sub(second_y_i, first_y_i); db[0] = sub(ex1, first_x_i);
    dd[0] = sub(second_x_i, first_x_i);
    da[1] = sub(second_x_i, first_x_i); db[1] = sub(ey1, first_y_i);
    dd[1] = sub(second_y_i, first_y_i);
    da[2] = sub(first_y_i, second_y_i); db[2] = sub(ex2, second_x_i);
    dd[2] = sub(first_x_i, second_x_i);
    da[3] = sub(first_x_i, second_x_i); db[3] = sub(ey2, second_y_i);
    dd[3] = sub(first_y_i, second_y_i);
  end

  logic         vld_a_q;
  sb_t          sb_a_q;
  logic [N-1:0] ma_q [4];
  logic [N-1:0] mb_q [4];
  logic [N-1:0] md_a_q [4];

  always_ff @(posedge clk_i) begin
    sb_a_q.outcome <= outc;
    sb_a_q.x1  <= first_x_i;
    sb_a_q.y1  <= first_y_i;
    sb_a_q.x2  <= second_x_i;
    sb_a_q.y2  <= second_y_i;
    sb_a_q.c1  <= c1;
    sb_a_q.c2  <= c2;
    sb_a_q.ex1 <= ex1;
    sb_a_q.ey1 <= ey1;
    sb_a_q.ex2 <= ex2;
    sb_a_q.ey2 <= ey2;
    for (int p = 0; p < 4; p++) begin
      sb_a_q.neg[p] <= da[p][N] ^ db[p][N] ^ dd[p][N];
      ma_q[p]   <= mag(da[p]);
      mb_q[p]   <= mag(db[p]);
      md_a_q[p] <= mag(dd[p]);
    end
  end

  // Stage M: one product per path.
  logic           vld_m_q;
  sb_t            sb_m_q;
  logic [2*N-1:0] prod_q [4];
  logic [N-1:0]   md_m_q [4];

  always_ff @(posedge clk_i) begin
    sb_m_q <= sb_a_q;
    for (int p = 0; p < 4; p++) begin
      prod_q[p] <= ma_q[p] * mb_q[p];
      md_m_q[p] <= md_a_q[p];
    end
  end

  logic [N-1:0] quo [4];
  for (genvar p = 0; p < 4; p++) begin : g_div
    lcw_div_pipe #(.CoordBits(N)) u_div (
      .clk_i      (clk_i),
      .dividend_i (prod_q[p]),
      .divisor_i  (md_m_q[p]),
      .quotient_o (quo[p])
    );
  end

  // Sideband delay line matching the divider depth.
  logic vld_d_q [N];
  sb_t  sb_d_q  [N];

  always_ff @(posedge clk_i) begin
    sb_d_q[0] <= sb_m_q;
    for (int k = 1; k < N; k++) sb_d_q[k] <= sb_d_q[k-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_m_q <= 1'b0;
      for (int k = 0; k < N; k++) vld_d_q[k] <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      vld_a_q    <= take;
      vld_m_q    <= vld_a_q;
      vld_d_q[0] <= vld_m_q;
      for (int k = 1; k < N; k++) vld_d_q[k] <= vld_d_q[k-1];
      result_valid_o <= vld_d_q[N-1];
    end
  end

  // Final stage: sign the quotients, add, test the side result, choose.
  function automatic logic [N+1:0] offset(input logic [N-1:0] base, input logic [N-1:0] q,
                                          input logic neg);
    logic [N:0] qs;
    qs = neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
    return {{2{base[N-1]}}, base} + {qs[N], qs};
  endfunction

  function automatic logic [2*N-1:0] resolve(
    input logic [3:0] code, input logic [N-1:0] ax, input logic [N-1:0] ay,
    input logic [N-1:0] ex, input logic [N-1:0] ey,
    input logic [N+1:0] side_y, input logic [N+1:0] tb_x);
    logic side_ok;
    side_ok = $signed(side_y) <= $signed({{2{bottom_q[N-1]}}, bottom_q}) &&
              $signed(side_y) >= $signed({{2{top_q[N-1]}}, top_q});
    if ((code[OC_LEFT] || code[OC_RIGHT]) && side_ok) return {ex, side_y[N-1:0]};
    else if (code[OC_ABOVE] || code[OC_BELOW])         return {tb_x[N-1:0], ey};
    else                                               return {ax, ay};
  endfunction

  sb_t            sb_f;
  logic [2*N-1:0] end1, end2;

  assign sb_f = sb_d_q[N-1];

  always_comb begin
    end1 = resolve(sb_f.c1, sb_f.x1, sb_f.y1, sb_f.ex1, sb_f.ey1,
                   offset(sb_f.y1, quo[0], sb_f.neg[0]),
                   offset(sb_f.x1, quo[1], sb_f.neg[1]));
    end2 = resolve(sb_f.c2, sb_f.x2, sb_f.y2, sb_f.ex2, sb_f.ey2,
                   offset(sb_f.y2, quo[2], sb_f.neg[2]),
                   offset(sb_f.x2, quo[3], sb_f.neg[3]));
  end

  always_ff @(posedge clk_i) begin
    outcome_o <= sb_f.outcome;
    if (sb_f.outcome == OUT_CLIP) begin
      clip_first_x_o  <= end1[2*N-1:N];
      clip_first_y_o  <= end1[N-1:0];
      clip_second_x_o <= end2[2*N-1:N];
      clip_second_y_o <= end2[N-1:0];
    end else begin
      clip_first_x_o  <= sb_f.x1;
      clip_first_y_o  <= sb_f.y1;
      clip_second_x_o <= sb_f.x2;
      clip_second_y_o <= sb_f.y2;
    end
  end

  `ASSERT_AT(a_take_enters, clk_i, rst_ni, take |=> vld_a_q)
  `ASSERT_AT(a_result_has_request, clk_i, rst_ni, result_valid_o |-> $past(take, LAT))
  `ASSERT_AT(a_unclipped_passes, clk_i, rst_ni,
    (result_valid_o && outcome_o != OUT_CLIP) |->
      (clip_first_x_o == $past(first_x_i, LAT) && clip_second_y_o == $past(second_y_i, LAT)))

endmodule
`default_nettype wire

// File: tb/line_clip_window_unit_tb.sv
// Self-checking testbench for the line clipping window unit.
`timescale 1ns / 100ps
module line_clip_window_unit_tb;
  import lcw_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int CLK_PERIOD = 12;
  localparam int PIPE_DEPTH = CW + 3;
  localparam int RANDOM_ITEMS = 1750;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    outcome_e oc;
    coord_t   fx, fy, sx, sy;
  } clip_res_t;

  typedef struct {
    coord_t   x1, y1, x2, y2;
    bit       typed;
    outcome_e oc;
  } seg_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic result_valid_o;
  logic [1:0] outcome_o;
  coord_t clip_first_x_o, clip_first_y_o, clip_second_x_o, clip_second_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  // Window as the block should currently hold it.
  longint win_left, win_right, win_top, win_bottom;

  clip_res_t pending_clips[$];
  int errors = 0;
  int segments_sent = 0;
  int results_seen = 0;
  int windows_used = 0;
  int clipped_seen = 0;

  line_clip_window_unit DUT (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned region_code(longint x, longint y);
    int unsigned c = 0;
    if (y < win_top)    c |= 1 << OC_ABOVE;
    if (y > win_bottom) c |= 1 << OC_BELOW;
    if (x > win_right)  c |= 1 << OC_RIGHT;
    if (x < win_left)   c |= 1 << OC_LEFT;
    return c;
  endfunction

  // Signed division in SystemVerilog truncates toward zero, as required.
  function automatic longint edge_offset(longint a, longint b, longint d);
    if (d == 0) return 0;
    return (a * b) / d;
  endfunction

  function automatic void pull_to_edge(longint ax, longint ay, int unsigned ac,
                                       longint bx, longint by,
                                       output longint ox, output longint oy);
    longint ex, ey;
    ox = ax;
    oy = ay;
    if (ac & ((1 << OC_RIGHT) | (1 << OC_LEFT))) begin
      ex = (ac & (1 << OC_RIGHT)) ? win_right : win_left;
      ey = ay + edge_offset(by - ay, ex - ax, bx - ax);
      if (ey <= win_bottom && ey >= win_top) begin
        ox = ex;
        oy = ey;
        return;
      end
    end
    if (ac & ((1 << OC_ABOVE) | (1 << OC_BELOW))) begin
      ey = (ac & (1 << OC_BELOW)) ? win_bottom : win_top;
      ox = ax + edge_offset(bx - ax, ey - ay, by - ay);
      oy = ey;
    end
  endfunction

  function automatic clip_res_t clip_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    clip_res_t r;
    longint ax = x1, ay = y1, bx = x2, by = y2;
    longint fx = ax, fy = ay, sx = bx, sy = by;
    int unsigned c1 = region_code(ax, ay);
    int unsigned c2 = region_code(bx, by);
    if (c1 == 0 && c2 == 0) begin
      r.oc = OUT_INSIDE;
    end else if ((c1 & c2) != 0) begin
      r.oc = OUT_REJECT;
    end else begin
      r.oc = OUT_CLIP;
      pull_to_edge(ax, ay, c1, bx, by, fx, fy);
      pull_to_edge(bx, by, c2, ax, ay, sx, sy);
    end
    r.fx = fx[CW-1:0];
    r.fy = fy[CW-1:0];
    r.sx = sx[CW-1:0];
    r.sy = sy[CW-1:0];
    return r;
  endfunction

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drives one request and records its expectation once it is taken.
  task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                              bit typed, outcome_e oc);
    clip_res_t want;
    start <= 1'b1;
    first_x_i <= x1;
    first_y_i <= y1;
    second_x_i <= x2;
    second_y_i <= y2;
    do @(posedge clk_i); while (busy);
    if (typed) begin
      want.oc = oc;
      want.fx = x1;
      want.fy = y1;
      want.sx = x2;
      want.sy = y2;
    end else begin
      want = clip_segment(x1, y1, x2, y2);
    end
    pending_clips.push_back(want);
    segments_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LEFT:   win_left = val;
      REG_RIGHT:  win_right = val;
      REG_TOP:    win_top = val;
      REG_BOTTOM: win_bottom = val;
      default: ;
    endcase
  endtask

  // Waits for the pipeline to drain, then reloads the whole window.
  task automatic set_window(coord_t l, coord_t r, coord_t t, coord_t b);
    hold_off(1);
    wait (pending_clips.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_TOP, t);
    write_reg(REG_BOTTOM, b);
    cfg_valid_i <= 1'b0;
    windows_used++;
  endtask

  function automatic coord_t pick_coord(longint lo, longint hi);
    longint v;
    int unsigned sel = $urandom_range(0, 9);
    if (sel < 6) begin
      v = (lo < hi ? lo : hi) - 300 + $urandom_range(0, 600 + (hi > lo ? hi - lo : lo - hi));
    end else if (sel < 9) begin
      v = $signed(coord_t'($urandom));
    end else begin
      v = $urandom_range(0, 1) ? 2047 : -2048;
    end
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[CW-1:0];
  endfunction

  task automatic random_burst(int count);
    int left = count;
    int burst;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        send_segment(pick_coord(win_left, win_right), pick_coord(win_top, win_bottom),
                     pick_coord(win_left, win_right), pick_coord(win_top, win_bottom),
                     1'b0, OUT_INSIDE);
        burst--;
        left--;
      end
      hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
  endtask

  always @(posedge clk_i) begin
    clip_res_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_clips.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_clips.pop_front();
        if (want.oc == OUT_CLIP) clipped_seen++;
        if (outcome_o !== want.oc) begin
          $error("outcome: expected %0d, got %0d", want.oc, outcome_o);
          errors++;
        end
        if (clip_first_x_o !== want.fx) begin
          $error("clip_first_x: expected %0d, got %0d", want.fx, clip_first_x_o);
          errors++;
        end
        if (clip_first_y_o !== want.fy) begin
          $error("clip_first_y: expected %0d, got %0d", want.fy, clip_first_y_o);
          errors++;
        end
        if (clip_second_x_o !== want.sx) begin
          $error("clip_second_x: expected %0d, got %0d", want.sx, clip_second_x_o);
          errors++;
        end
        if (clip_second_y_o !== want.sy) begin
          $error("clip_second_y: expected %0d, got %0d", want.sy, clip_second_y_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #(5ms);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    seg_row_t rows[$];
    int per_phase;
    win_left = WIN_LEFT_RST;
    win_right = WIN_RIGHT_RST;
    win_top = WIN_TOP_RST;
    win_bottom = WIN_BOTTOM_RST;

    // Typed rows are trivially inside or rejected against the reset window.
    rows = '{
      '{200, 200, 300, 300, 1'b1, OUT_INSIDE},
      '{150, 100, 450, 350, 1'b1, OUT_INSIDE},
      '{0, 200, 100, 300, 1'b1, OUT_REJECT},
      '{-2048, -2048, 2047, -2048, 1'b1, OUT_REJECT},
      '{2047, 2047, 2047, -2048, 1'b1, OUT_REJECT},
      '{-2048, 2047, -1, 2047, 1'b1, OUT_REJECT},
      '{0, 200, 300, 200, 1'b0, OUT_INSIDE},
      '{300, 0, 300, 500, 1'b0, OUT_INSIDE},
      '{-2048, -2048, 2047, 2047, 1'b0, OUT_INSIDE},
      '{2047, -2048, -2048, 2047, 1'b0, OUT_INSIDE},
      '{100, 50, 500, 400, 1'b0, OUT_INSIDE},
      '{100, 0, 300, 200, 1'b0, OUT_INSIDE},
      '{0, 340, 460, 1000, 1'b0, OUT_INSIDE},
      '{460, 120, -10, 360, 1'b0, OUT_INSIDE},
      '{149, 99, 451, 351, 1'b0, OUT_INSIDE}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_segment(rows[i].x1, rows[i].y1, rows[i].x2, rows[i].y2, rows[i].typed, rows[i].oc);
    hold_off(3);

    per_phase = RANDOM_ITEMS / 7;
    random_burst(per_phase);
    set_window(-2048, 2047, -2048, 2047);
    random_burst(per_phase / 2);
    // Left beyond right and top beyond bottom exercise the doubled edge bits.
    set_window(300, -300, 200, -200);
    random_burst(per_phase);
    set_window(0, 0, 0, 0);
    random_burst(per_phase / 2);
    set_window(-1000, -900, 1500, 2000);
    random_burst(per_phase);
    repeat (3) begin
      set_window($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                 $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
      random_burst(per_phase / 2);
      set_window(-($urandom_range(0, 1000)), $urandom_range(0, 1000),
                 -($urandom_range(0, 1000)), $urandom_range(0, 1000));
      random_burst(per_phase / 2);
    end

    hold_off(1);
    wait (pending_clips.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    $display("Sent %0d segments under %0d window settings; %0d results checked, %0d clipped.",
             segments_sent, windows_used + 1, results_seen, clipped_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lcw_pkg.sv
rtl/lcw_div_pipe.sv
rtl/line_clip_window_unit.sv
tb/line_clip_window_unit_tb.sv
